// ===== hw/rtl/jse_pkg.sv =====
// jse_pkg: types, constants and helper functions for the JSON string escaper.
// Used by jse_front, jse_queue, jse_back and json_string_escaper.
`default_nettype none

package jse_pkg;

	localparam int QueueDepth = 2;
	localparam int CpW        = 21;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       bad_utf8;
	} out_item_t;

	// escape job handed from front to back
	typedef struct packed {
		logic           is_cp;
		logic           bad;
		logic           esc;
		logic [CpW-1:0] val;
	} job_t;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_R     = 8'h72;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_HT = 8'h09;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_CR = 8'h0D;

	localparam logic [6:0] CLS_ASCII = 7'h00;
	localparam logic [6:0] CLS_T80   = 7'h10;
	localparam logic [6:0] CLS_T90   = 7'h40;
	localparam logic [6:0] CLS_TA0   = 7'h20;
	localparam logic [6:0] CLS_BAD   = 7'h08;
	localparam logic [6:0] CLS_L2    = 7'h02;
	localparam logic [6:0] CLS_E0    = 7'h0A;
	localparam logic [6:0] CLS_ED    = 7'h04;
	localparam logic [6:0] CLS_L3    = 7'h03;
	localparam logic [6:0] CLS_F0    = 7'h0B;
	localparam logic [6:0] CLS_L4    = 7'h06;
	localparam logic [6:0] CLS_F4    = 7'h05;

	localparam logic [6:0] MASK_ANY = 7'h70;
	localparam logic [6:0] MASK_ED  = 7'h50;
	localparam logic [6:0] MASK_F4  = 7'h10;
	localparam logic [6:0] MASK_E0  = 7'h20;
	localparam logic [6:0] MASK_F0  = 7'h60;

	function automatic logic [6:0] byte_class(input logic [7:0] b);
		logic [6:0] c;
		priority if (b < 8'h80) c = CLS_ASCII;
		else if (b < 8'h90) c = CLS_T80;
		else if (b < 8'hA0) c = CLS_T90;
		else if (b < 8'hC0) c = CLS_TA0;
		else if (b < 8'hC2) c = CLS_BAD;
		else if (b < 8'hE0) c = CLS_L2;
		else if (b == 8'hE0) c = CLS_E0;
		else if (b == 8'hED) c = CLS_ED;
		else if (b < 8'hF0) c = CLS_L3;
		else if (b == 8'hF0) c = CLS_F0;
		else if (b < 8'hF4) c = CLS_L4;
		else if (b == 8'hF4) c = CLS_F4;
		else c = CLS_BAD;
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jse_front.sv =====
// jse_front: takes raw bytes, runs the UTF-8 decoder state and turns each complete
// character or malformed byte into an escape job. Depends on jse_pkg.
`default_nettype none

module jse_front import jse_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          push_valid,
	input  wire logic     push_ready,
	output job_t          push_job
);

	logic [1:0]     tails_q, tails_d, tails_dec;
	logic [CpW-1:0] accum_q, accum_d, acc_shift;
	logic [6:0]     mask_q, mask_d, cls, lead_mask;
	logic           err_q, err_d, miss, has_job, accept;
	logic [1:0]     lead_cnt;
	logic [7:0]     b, init;

	assign b         = in_item.in_byte;
	assign cls       = byte_class(b);
	assign acc_shift = {accum_q[CpW-7:0], b[5:0]};
	assign miss      = ((cls & mask_q) == 7'd0);
	assign tails_dec = tails_q - 2'd1;
	assign init      = (cls >= 7'h20) ? 8'd0 : ((8'hFF >> cls) & b);
	assign accept    = in_valid && in_ready;
	assign in_ready  = push_ready;
	assign push_valid = in_valid && has_job;

	always_comb begin
		unique case (cls)
			CLS_L2: begin lead_cnt = 2'd1; lead_mask = MASK_ANY; end
			CLS_L3: begin lead_cnt = 2'd2; lead_mask = MASK_ANY; end
			CLS_ED: begin lead_cnt = 2'd2; lead_mask = MASK_ED; end
			CLS_F4: begin lead_cnt = 2'd3; lead_mask = MASK_F4; end
			CLS_L4: begin lead_cnt = 2'd3; lead_mask = MASK_ANY; end
			CLS_E0: begin lead_cnt = 2'd2; lead_mask = MASK_E0; end
			CLS_F0: begin lead_cnt = 2'd3; lead_mask = MASK_F0; end
			default: begin lead_cnt = 2'd0; lead_mask = MASK_ANY; end
		endcase
	end

	always_comb begin
		tails_d  = tails_q;
		accum_d  = accum_q;
		mask_d   = mask_q;
		err_d    = err_q;
		has_job  = 1'b0;
		push_job = '0;
		priority if (tails_q != 2'd0) begin
			accum_d = acc_shift;
			err_d   = err_q | miss;
			mask_d  = MASK_ANY;
			tails_d = tails_dec;
			if (tails_dec == 2'd0) begin
				has_job        = 1'b1;
				push_job.is_cp = 1'b1;
				push_job.bad   = err_q | miss;
				push_job.val   = acc_shift;
				accum_d        = '0;
				mask_d         = '0;
				err_d          = 1'b0;
			end
		end else if (b < 8'h20) begin
			has_job        = 1'b1;
			push_job.esc   = 1'b1;
			push_job.val   = {{(CpW-8){1'b0}}, b};
			unique case (b)
				CTL_BS: push_job.val[7:0] = CH_B;
				CTL_HT: push_job.val[7:0] = CH_T;
				CTL_LF: push_job.val[7:0] = CH_N;
				CTL_FF: push_job.val[7:0] = CH_F;
				CTL_CR: push_job.val[7:0] = CH_R;
				default: begin
					push_job.is_cp = 1'b1;
					push_job.esc   = 1'b0;
				end
			endcase
		end else if (b < 8'h80) begin
			has_job      = 1'b1;
			push_job.esc = (b == CH_BSL) || (b == CH_QUOTE);
			push_job.val = {{(CpW-8){1'b0}}, b};
		end else begin
			if (lead_cnt == 2'd0) begin
				has_job        = 1'b1;
				push_job.is_cp = 1'b1;
				push_job.bad   = 1'b1;
			end else begin
				tails_d = lead_cnt;
				accum_d = {{(CpW-8){1'b0}}, init};
				mask_d  = lead_mask;
				err_d   = 1'b0;
			end
		end
		if (in_item.end_of_string) begin
			tails_d = '0;
			accum_d = '0;
			mask_d  = '0;
			err_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tails_q <= '0;
			accum_q <= '0;
			mask_q  <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			tails_q <= tails_d;
			accum_q <= accum_d;
			mask_q  <= mask_d;
			err_q   <= err_d;
		end
	end

`ifndef SYNTHESIS
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(tails_q == 2'd0) |-> (mask_q == 7'd0 && accum_q == '0 && !err_q))
		else $error("decoder state not clear between sequences");
	a_pending_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(tails_q != 2'd0) |-> (mask_q != 7'd0))
		else $error("tail pending without class mask");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/jse_queue.sv =====
// jse_queue: short register queue of escape jobs between front and back.
// Depends on jse_pkg.
`default_nettype none

module jse_queue import jse_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire job_t push_job,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            slots_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != CntW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slots_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue overfilled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/jse_back.sv =====
// jse_back: expands one escape job into its output bytes, one per transfer,
// including the surrogate-pair split. Depends on jse_pkg.
`default_nettype none

module jse_back import jse_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  wire job_t pop_job,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_item
);

	logic           busy_q, cp_q, bad_q, esc_q, pair_q;
	logic [7:0]     chr_q;
	logic [15:0]    w0_q, w1_q, word;
	logic [3:0]     idx_q, last_idx;
	logic [2:0]     pos;
	logic [CpW-1:0] cp;
	logic           bmp, fire, done, load;
	logic [25:0]    s;
	logic [15:0]    hi, lo;

	assign cp  = pop_job.val;
	assign bmp = (cp <= CpW'(24'hD7FF)) || (cp >= CpW'(24'hE000) && cp <= CpW'(24'hFFFF));
	assign s   = {5'd0, cp} - 26'h0010000;
	assign hi  = s[25:10] + 16'hD800;
	assign lo  = {6'b110111, s[9:0]};

	assign last_idx  = cp_q ? (pair_q ? 4'd11 : 4'd5) : (esc_q ? 4'd1 : 4'd0);
	assign out_valid = busy_q;
	assign fire      = busy_q && out_ready;
	assign done      = fire && (idx_q == last_idx);
	assign pop_ready = !busy_q || done;
	assign load      = pop_valid && pop_ready;

	always_comb begin
		if (idx_q >= 4'd6) begin
			pos  = 3'(idx_q - 4'd6);
			word = w1_q;
		end else begin
			pos  = idx_q[2:0];
			word = w0_q;
		end
		out_item.run_last = (idx_q == last_idx);
		out_item.bad_utf8 = bad_q;
		if (!cp_q) begin
			out_item.out_byte = (esc_q && idx_q == 4'd0) ? CH_BSL : chr_q;
		end else begin
			unique case (pos)
				3'd0:    out_item.out_byte = CH_BSL;
				3'd1:    out_item.out_byte = CH_U;
				3'd2:    out_item.out_byte = hex_char(word[15:12]);
				3'd3:    out_item.out_byte = hex_char(word[11:8]);
				3'd4:    out_item.out_byte = hex_char(word[7:4]);
				3'd5:    out_item.out_byte = hex_char(word[3:0]);
				default: out_item.out_byte = CH_BSL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= pop_job.is_cp;
			bad_q  <= pop_job.bad;
			esc_q  <= pop_job.esc;
			chr_q  <= pop_job.val[7:0];
			pair_q <= !bmp;
			w0_q   <= bmp ? cp[15:0] : hi;
			w1_q   <= lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 4'd1;
		end
	end

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= last_idx))
		else $error("byte index past end of escape");
	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !cp_q) |-> !bad_q)
		else $error("plain character flagged as malformed");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/json_string_escaper.sv =====
// Path: the queue registers each job, then the back end loads it and drives the output.
// Throughput: one input byte per cycle while out_ready is high and each yields at most
// one output byte; otherwise set by the back-end byte sequencer: one output byte per
// cycle while out_ready is high (1, 2, 6 or 12 per job). Lead and pending tail bytes give no output.
// Reset: asynchronous, active low; decoder state, queue and back-end clear at once.
// json_string_escaper: top level; depends on jse_pkg, jse_front, jse_queue, jse_back.
`default_nettype none

module json_string_escaper import jse_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	job_t push_job, pop_job;

	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	jse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
